FILE: design/acm_pkg.sv
`timescale 1ns / 1ps
// Shared constants of the accumulator machine core: widths, command codes,
// status codes and opcodes. No dependencies.
package acm_pkg;

   localparam int WORD_W            = 32;
   localparam int ADDR_W            = 12;
   localparam int PC_W              = 13;
   localparam int LIMIT_W           = 31;
   localparam int MEM_WORDS_DEFAULT = 1024;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd65533;

   // Commands carried by an input transfer.
   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_EXECUTE = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // Status codes of a result.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_OUTPUT   = 3'd1;
   localparam logic [2:0] ST_NEWLINE  = 3'd2;
   localparam logic [2:0] ST_HALTED   = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;
   localparam logic [2:0] ST_DIVZERO  = 3'd5;
   localparam logic [2:0] ST_BADADDR  = 3'd6;
   localparam logic [2:0] ST_STOPPED  = 3'd7;

   // Opcodes (upper part of an instruction word).
   localparam logic [7:0] OP_NONE   = 8'h00;
   localparam logic [7:0] OP_READ   = 8'h10;
   localparam logic [7:0] OP_WRITE  = 8'h11;
   localparam logic [7:0] OP_LOAD   = 8'h20;
   localparam logic [7:0] OP_STORE  = 8'h21;
   localparam logic [7:0] OP_ADD    = 8'h30;
   localparam logic [7:0] OP_SUB    = 8'h31;
   localparam logic [7:0] OP_DIV    = 8'h32;
   localparam logic [7:0] OP_MUL    = 8'h33;
   localparam logic [7:0] OP_MOD    = 8'h34;
   localparam logic [7:0] OP_POW    = 8'h35;
   localparam logic [7:0] OP_BR     = 8'h40;
   localparam logic [7:0] OP_BRNEG  = 8'h41;
   localparam logic [7:0] OP_BRZERO = 8'h42;
   localparam logic [7:0] OP_HALT   = 8'h43;
   localparam logic [7:0] OP_NEWLN  = 8'h50;

endpackage

FILE: design/accumulator_machine_core.sv
`timescale 1ns / 1ps
// Single-accumulator machine: word memory, sequencer and arithmetic.
// Depends on acm_pkg and acm_divider.
//
// The block handles one transfer at a time. After reset it first clears its
// memory, one word a cycle, holding req_stall high. A memory write, restart or
// refused execute goes from idle straight to done; an executed instruction
// passes through fetch, operand read, execute and, for arithmetic, range check
// on the single read port, going from operand read to done when its operand
// address lies beyond the memory; divide and modulus wait for the bit-serial
// divider; power runs a multiply and a check state per product. A finished
// result waits in the output register while the next transfer is accepted.
module accumulator_machine_core import acm_pkg::*; #(
   parameter int MEM_WORDS = MEM_WORDS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_cmd,
   input  logic [ADDR_W-1:0]         req_address,
   input  logic signed [WORD_W-1:0]  req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_status,
   output logic signed [WORD_W-1:0]  rsp_value,
   output logic                      rsp_input_taken,
   output logic [PC_W-1:0]           rsp_program_counter,
   input  logic                      csr_write_enable,
   input  logic [LIMIT_W-1:0]        csr_write_data
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam logic [PC_W-1:0] MEM_LIMIT = PC_W'(MEM_WORDS);

   typedef enum logic [8:0] {
      S_CLEAR   = 9'b000000001,
      S_IDLE    = 9'b000000010,
      S_FETCH   = 9'b000000100,
      S_EXEC    = 9'b000001000,
      S_DIV     = 9'b000010000,
      S_POW_MUL = 9'b000100000,
      S_POW_CHK = 9'b001000000,
      S_CHECK   = 9'b010000000,
      S_DONE    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [WORD_W-1:0] acc_ff, acc_in;
   logic [PC_W-1:0]          pc_ff, pc_in;
   logic                     stopped_ff, stopped_in;
   logic [LIMIT_W-1:0]       limit_ff, limit_in;
   logic [AW-1:0]            clr_ff, clr_in;
   logic signed [WORD_W-1:0] word_ff, word_in;
   logic [7:0]               op_ff, op_in;
   logic [AW-1:0]            ix_ff, ix_in;
   logic signed [63:0]       arith_ff, arith_in;
   logic signed [WORD_W-1:0] pow_r_ff, pow_r_in;
   logic [WORD_W-2:0]        pow_e_ff, pow_e_in;
   logic [2:0]               res_status_ff, res_status_in;
   logic                     res_taken_ff, res_taken_in;
   logic                     res_show_ff, res_show_in;
   logic signed [WORD_W-1:0] res_mem_ff, res_mem_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [2:0]               rsp_status_ff, rsp_status_in;
   logic signed [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_taken_ff, rsp_taken_in;
   logic [PC_W-1:0]          rsp_pc_ff, rsp_pc_in;

   // Memory port signals.
   logic signed [WORD_W-1:0] mem [MEM_WORDS];
   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic signed [WORD_W-1:0] mem_wdata;
   logic [AW-1:0]            mem_raddr;
   logic signed [WORD_W-1:0] mem_rdata_ff;

   // Divider interface.
   logic                     div_start;
   logic                     div_done;
   logic signed [WORD_W:0]   div_quo;
   logic signed [WORD_W-1:0] div_rem;

   // Decode and arithmetic helpers.
   logic                     accept;
   logic                     out_free;
   logic [19:0]              op_full;
   logic [ADDR_W-1:0]        op_addr;
   logic                     op_small;
   logic [7:0]               op_dec;
   logic                     uses_addr;
   logic signed [63:0]       lim64;
   logic signed [63:0]       prod;
   logic                     arith_beyond;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign op_full  = mem_rdata_ff[WORD_W-1:ADDR_W];
   assign op_addr  = mem_rdata_ff[ADDR_W-1:0];
   assign op_small = !mem_rdata_ff[WORD_W-1] && (op_full[19:8] == 12'd0);
   assign op_dec   = op_small ? op_full[7:0] : OP_NONE;
   assign uses_addr = (op_dec == OP_READ) || (op_dec == OP_WRITE) ||
                      (op_dec == OP_LOAD) || (op_dec == OP_STORE) ||
                      (op_dec == OP_ADD)  || (op_dec == OP_SUB)   ||
                      (op_dec == OP_DIV)  || (op_dec == OP_MUL)   ||
                      (op_dec == OP_MOD)  || (op_dec == OP_POW)   ||
                      (op_dec == OP_BR)   || (op_dec == OP_BRNEG) ||
                      (op_dec == OP_BRZERO);

   // Range check of a registered result against the configured limit.
   assign lim64        = $signed({33'd0, limit_ff});
   assign arith_beyond = (arith_ff > lim64) || (arith_ff < -lim64);

   // A single 32 by 32 multiplier, shared by multiply and power.
   assign prod = (state_ff == S_POW_MUL) ? pow_r_ff * acc_ff : acc_ff * mem_rdata_ff;

   acm_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (acc_ff),
      .divisor   (mem_rdata_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Sequencer and datapath.
   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      pc_in         = pc_ff;
      stopped_in    = stopped_ff;
      limit_in      = csr_write_enable ? csr_write_data : limit_ff;
      clr_in        = clr_ff;
      word_in       = word_ff;
      op_in         = op_ff;
      ix_in         = ix_ff;
      arith_in      = arith_ff;
      pow_r_in      = pow_r_ff;
      pow_e_in      = pow_e_ff;
      res_status_in = res_status_ff;
      res_taken_in  = res_taken_ff;
      res_show_in   = res_show_ff;
      res_mem_in    = res_mem_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_taken_in  = rsp_taken_ff;
      rsp_pc_in     = rsp_pc_ff;
      mem_we        = 1'b0;
      mem_waddr     = clr_ff;
      mem_wdata     = '0;
      mem_raddr     = pc_ff[AW-1:0];
      div_start     = 1'b0;

      case (state_ff)
         // Clearing pass after reset.
         S_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(MEM_WORDS-1)) begin
               state_in = S_IDLE;
            end
         end

         // Take a transfer; the fetch read at pc is issued here.
         S_IDLE: begin
            if (accept) begin
               word_in       = req_word;
               res_status_in = ST_OK;
               res_taken_in  = 1'b0;
               res_show_in   = 1'b0;
               state_in      = S_DONE;
               case (req_cmd)
                  CMD_WRITE: begin
                     if (PC_W'(req_address) < MEM_LIMIT) begin
                        mem_we    = 1'b1;
                        mem_waddr = req_address[AW-1:0];
                        mem_wdata = req_word;
                     end else begin
                        res_status_in = ST_BADADDR;
                     end
                  end
                  CMD_RESTART: begin
                     pc_in      = '0;
                     acc_in     = '0;
                     stopped_in = 1'b0;
                  end
                  CMD_EXECUTE: begin
                     if (stopped_ff) begin
                        res_status_in = ST_STOPPED;
                     end else if (pc_ff >= MEM_LIMIT) begin
                        res_status_in = ST_BADADDR;
                        stopped_in    = 1'b1;
                     end else begin
                        state_in = S_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Decode the fetched word and read the operand.
         S_FETCH: begin
            pc_in = pc_ff + 1'b1;
            op_in = op_dec;
            ix_in = uses_addr ? op_addr[AW-1:0] : '0;
            mem_raddr = ix_in;
            if (uses_addr && (PC_W'(op_addr) >= MEM_LIMIT)) begin
               res_status_in = ST_BADADDR;
               stopped_in    = 1'b1;
               state_in      = S_DONE;
            end else begin
               state_in = S_EXEC;
            end
         end

         // Execute with the operand word on the read port.
         S_EXEC: begin
            state_in = S_DONE;
            case (op_ff)
               OP_READ: begin
                  mem_we       = 1'b1;
                  mem_waddr    = ix_ff;
                  mem_wdata    = word_ff;
                  res_taken_in = 1'b1;
               end
               OP_WRITE: begin
                  res_status_in = ST_OUTPUT;
                  res_show_in   = 1'b1;
                  res_mem_in    = mem_rdata_ff;
               end
               OP_LOAD:  acc_in = mem_rdata_ff;
               OP_STORE: begin
                  mem_we    = 1'b1;
                  mem_waddr = ix_ff;
                  mem_wdata = acc_ff;
               end
               OP_ADD: begin
                  arith_in = 64'(acc_ff) + 64'(mem_rdata_ff);
                  state_in = S_CHECK;
               end
               OP_SUB: begin
                  arith_in = 64'(acc_ff) - 64'(mem_rdata_ff);
                  state_in = S_CHECK;
               end
               OP_MUL: begin
                  arith_in = prod;
                  state_in = S_CHECK;
               end
               OP_DIV, OP_MOD: begin
                  if (mem_rdata_ff == '0) begin
                     res_status_in = ST_DIVZERO;
                     stopped_in    = 1'b1;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               OP_POW: begin
                  // Trivial bases and exponents resolve at once.
                  state_in = S_CHECK;
                  if (mem_rdata_ff == '0) begin
                     arith_in = 64'sd1;
                  end else if (acc_ff == 32'sd1) begin
                     arith_in = 64'sd1;
                  end else if (acc_ff == -32'sd1) begin
                     arith_in = mem_rdata_ff[0] ? -64'sd1 : 64'sd1;
                  end else if (acc_ff == '0) begin
                     if (mem_rdata_ff[WORD_W-1]) begin
                        res_status_in = ST_OVERFLOW;
                        stopped_in    = 1'b1;
                        state_in      = S_DONE;
                     end else begin
                        arith_in = '0;
                     end
                  end else if (mem_rdata_ff[WORD_W-1]) begin
                     arith_in = '0;
                  end else begin
                     pow_r_in = 32'sd1;
                     pow_e_in = mem_rdata_ff[WORD_W-2:0];
                     state_in = S_POW_MUL;
                  end
               end
               OP_BR: pc_in = PC_W'(ix_ff);
               OP_BRNEG: begin
                  if (acc_ff[WORD_W-1]) begin
                     pc_in = PC_W'(ix_ff);
                  end
               end
               OP_BRZERO: begin
                  if (acc_ff == '0) begin
                     pc_in = PC_W'(ix_ff);
                  end
               end
               OP_HALT: begin
                  res_status_in = ST_HALTED;
                  stopped_in    = 1'b1;
               end
               OP_NEWLN: res_status_in = ST_NEWLINE;
               default: begin
               end
            endcase
         end

         // Wait for the divider.
         S_DIV: begin
            if (div_done) begin
               arith_in = (op_ff == OP_DIV) ? 64'(div_quo) : 64'(div_rem);
               state_in = S_CHECK;
            end
         end

         // Repeated multiplication for power, checked after each product.
         S_POW_MUL: begin
            arith_in = prod;
            state_in = S_POW_CHK;
         end

         S_POW_CHK: begin
            if (arith_beyond) begin
               res_status_in = ST_OVERFLOW;
               stopped_in    = 1'b1;
               state_in      = S_DONE;
            end else begin
               pow_r_in = arith_ff[WORD_W-1:0];
               pow_e_in = pow_e_ff - 1'b1;
               state_in = (pow_e_ff == 31'd1) ? S_CHECK : S_POW_MUL;
            end
         end

         // Commit an arithmetic result or stop on overflow.
         S_CHECK: begin
            if (arith_beyond) begin
               res_status_in = ST_OVERFLOW;
               stopped_in    = 1'b1;
            end else begin
               acc_in = arith_ff[WORD_W-1:0];
            end
            state_in = S_DONE;
         end

         // Hand the result to the output register once it is free.
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_show_ff ? res_mem_ff : acc_ff;
               rsp_taken_in  = res_taken_ff;
               rsp_pc_in     = pc_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Word memory, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         acc_ff       <= '0;
         pc_ff        <= '0;
         stopped_ff   <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         pc_ff        <= pc_in;
         stopped_ff   <= stopped_in;
         limit_ff     <= limit_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff       <= word_in;
      op_ff         <= op_in;
      ix_ff         <= ix_in;
      arith_ff      <= arith_in;
      pow_r_ff      <= pow_r_in;
      pow_e_ff      <= pow_e_in;
      res_status_ff <= res_status_in;
      res_taken_ff  <= res_taken_in;
      res_show_ff   <= res_show_in;
      res_mem_ff    <= res_mem_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_taken_ff  <= rsp_taken_in;
      rsp_pc_ff     <= rsp_pc_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_value           = rsp_value_ff;
   assign rsp_input_taken     = rsp_taken_ff;
   assign rsp_program_counter = rsp_pc_ff;

   // A new result appears only when the sequencer leaves its final state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the final state");

   // The accumulator only changes on restart, load or a committed result.
   a_acc_changes: assert property (@(posedge clock) disable iff (reset)
      !$stable(acc_ff) |-> ($past(state_ff == S_IDLE) || $past(state_ff == S_EXEC) ||
                            $past(state_ff == S_CHECK)))
      else $error("accumulator changed in an unexpected state");

   // The divider reports completion only while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished while not awaited");

   // Memory writes stay within the memory.
   a_mem_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (PC_W'(mem_waddr) < MEM_LIMIT))
      else $error("memory write beyond the last word");

endmodule

FILE: design/acm_divider.sv
`timescale 1ns / 1ps
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on acm_pkg for the word width.
module acm_divider import acm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [WORD_W-1:0] dividend,
   input  logic signed [WORD_W-1:0] divisor,
   output logic                     done,
   output logic signed [WORD_W:0]   quotient,
   output logic signed [WORD_W-1:0] remainder
);

   localparam int CNT_W = $clog2(WORD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W:0]   rem_ff, rem_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] dvs_ff, dvs_in;
   logic              qneg_ff, qneg_in;
   logic              rneg_ff, rneg_in;
   logic [WORD_W:0]   shifted;
   logic [WORD_W+1:0] trial;

   // One restoring step per cycle on the magnitudes.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      shifted = {rem_ff[WORD_W-1:0], quo_ff[WORD_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[WORD_W-1] ? WORD_W'(-dividend) : WORD_W'(dividend);
         dvs_in  = divisor[WORD_W-1] ? WORD_W'(-divisor) : WORD_W'(divisor);
         qneg_in = dividend[WORD_W-1] ^ divisor[WORD_W-1];
         rneg_in = dividend[WORD_W-1];
      end else if (busy_ff) begin
         if (!trial[WORD_W+1]) begin
            rem_in = trial[WORD_W:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WORD_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
   end

   // Sign correction: the remainder follows the dividend.
   assign done      = done_ff;
   assign quotient  = qneg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign remainder = rneg_ff ? -$signed(rem_ff[WORD_W-1:0]) : $signed(rem_ff[WORD_W-1:0]);

endmodule
